/* rtl/core/first_fit_aligned_block_allocator_macros.svh */
// Assertion macros for the block allocator.
`ifndef FIRST_FIT_ALIGNED_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_ALIGNED_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FFA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define FFA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define FFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/core/ffa_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Allocator package
// Status, command and configuration codes and the table entry type shared by the allocator modules.
// ---------------------------------------------------------------------------
package ffa_pkg;
    localparam logic       CMD_ALLOC   = 1'b0;
    localparam logic       CMD_RELEASE = 1'b1;
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVAL    = 2'd1;
    localparam logic [1:0] ST_NOMEM    = 2'd2;
    localparam logic [1:0] ST_NOMATCH  = 2'd3;
    localparam logic [1:0] CFG_BASE    = 2'd0;
    localparam logic [1:0] CFG_START   = 2'd1;
    localparam logic [1:0] CFG_LENGTH  = 2'd2;

    // One table entry.
    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
        logic        is_free;
    } t_entry;
endpackage

/* rtl/core/ffa_fit_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fit check unit
// Registered first-fit test of one table entry against the current request.
// ---------------------------------------------------------------------------
module ffa_fit_unit (
    input  logic           i_clk,
    input  ffa_pkg::t_entry i_entry,
    input  logic [32:0]    i_rsize,
    input  logic [32:0]    i_amask,
    output logic           o_fit,
    output logic [31:0]    o_aligned,
    output logic [31:0]    o_pad,
    output logic [31:0]    o_tail
);
    import ffa_pkg::*;

    logic [32:0] aligned;
    logic [32:0] pad;
    logic [32:0] rest;
    logic        fit;

    always_comb begin
        aligned = ({1'b0, i_entry.start} + i_amask) & ~i_amask;
        pad     = aligned - {1'b0, i_entry.start};
        rest    = {1'b0, i_entry.length} - pad;
        fit     = i_entry.is_free && !aligned[32] && ({1'b0, i_entry.length} >= pad)
                  && (rest >= i_rsize);
    end

    always_ff @(posedge i_clk) begin
        o_fit     <= fit;
        o_aligned <= aligned[31:0];
        o_pad     <= pad[31:0];
        o_tail    <= rest[31:0] - i_rsize[31:0];
    end
endmodule

/* rtl/core/first_fit_aligned_block_allocator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// First-fit aligned block allocator
// Table of heap blocks with aligned allocation, splitting and coalescing.
// ---------------------------------------------------------------------------
// An item first scans the table entry by entry up to the first fit or match:
// one state reads the entry memory, one passes the read data through the
// shared fit unit, and one evaluates the result. An allocate then moves the
// entries above the chosen one up, reading and then writing each one, and
// writes up to three entries. A release reads both neighbours, writes the
// merged entry and moves the entries above it down the same way. The table
// lives in one single-port memory. The block is not ready while an item is in
// work or while its result waits to be taken, and after reset while the first
// entry is written. Writing heap_start or heap_length while idle resets the
// table to one free block; unused entries are never relied on. BASE_ALIGN must
// be a power of two.
module first_fit_aligned_block_allocator #(
    parameter int MAX_BLOCKS = 64,
    parameter int BASE_ALIGN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_command,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_request_alignment,
    input  logic [31:0] i_release_offset,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_granted_offset,
    output logic [31:0] o_granted_size,
    output logic [31:0] o_granted_address,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ffa_pkg::*;
`include "first_fit_aligned_block_allocator_macros.svh"

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int BW = $clog2(BASE_ALIGN);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_EVAL = 4'd3;
    localparam logic [3:0] S_SHRD = 4'd4;
    localparam logic [3:0] S_SHWR = 4'd5;
    localparam logic [3:0] S_WR   = 4'd6;
    localparam logic [3:0] S_RDN  = 4'd7;
    localparam logic [3:0] S_MRGN = 4'd8;
    localparam logic [3:0] S_RDP  = 4'd9;
    localparam logic [3:0] S_MRGP = 4'd10;
    localparam logic [3:0] S_DNRD = 4'd11;
    localparam logic [3:0] S_DNWR = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;
    localparam logic [3:0] S_INIT = 4'd14;

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rdata;

    logic [3:0]    r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_ptr;
    logic [1:0]    r_extra;
    logic [1:0]    r_wstep;
    logic          r_cmd;
    logic [32:0]   r_rsize;
    logic [32:0]   r_amask;
    logic [31:0]   r_off;
    logic [31:0]   r_base;
    logic [31:0]   r_hstart;
    logic [31:0]   r_hlen;
    t_entry        r_cur;
    logic          r_mnext;
    logic [1:0]    r_status;
    logic [31:0]   r_goff;
    logic [31:0]   r_gsize;
    logic          r_ovalid;
    logic [31:0]   r_aligned;
    logic [31:0]   r_pad;
    logic [31:0]   r_tail;

    // Memory port, driven by the sequencer.
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    t_entry        mem_wdata;

    logic        fit;
    logic [31:0] f_aligned, f_pad, f_tail;

    ffa_fit_unit u_fit (
        .i_clk    (i_clk),
        .i_entry  (r_rdata),
        .i_rsize  (r_rsize),
        .i_amask  (r_amask),
        .o_fit    (fit),
        .o_aligned(f_aligned),
        .o_pad    (f_pad),
        .o_tail   (f_tail)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    logic          acc;
    logic [32:0]   align_eff;
    logic [32:0]   rs;
    logic          cfg_init;
    logic [CW-1:0] shift_src;
    logic          prev_free;

    assign acc       = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE) && !r_ovalid;
    assign cfg_init  = i_cfg_we && (i_cfg_index == CFG_START || i_cfg_index == CFG_LENGTH);
    // Whether the entry below the released one is free, valid while the release sequence reads it.
    assign prev_free = (r_idx != '0) && r_rdata.is_free;

    always_comb begin
        align_eff = (i_request_alignment == 32'd0) ? 33'(BASE_ALIGN)
                                                   : {1'b0, i_request_alignment};
        rs = {1'b0, i_request_size} + 33'(BASE_ALIGN - 1);
        if (BW > 0) begin
            rs = (rs >> BW) << BW;
        end
    end

    // Memory address and write data per state.
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_idx[AW-1:0];
        mem_wdata = r_cur;
        shift_src = r_ptr - 1'b1;
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_addr  = '0;
                mem_wdata = '{start: r_hstart, length: r_hlen, is_free: 1'b1};
            end
            S_SHRD: begin
                mem_addr = shift_src[AW-1:0];
            end
            S_SHWR: begin
                mem_we    = 1'b1;
                mem_addr  = AW'(r_ptr - 1'b1 + CW'(r_extra));
                mem_wdata = r_rdata;
            end
            S_WR: begin
                mem_we = 1'b1;
                if (r_wstep == 2'd0 && r_pad != 32'd0) begin
                    mem_wdata = '{start: r_cur.start, length: r_pad, is_free: 1'b1};
                end else if (r_wstep == 2'd2 || (r_wstep == 2'd1 && r_pad == 32'd0)) begin
                    mem_addr  = AW'(r_ptr);
                    mem_wdata = '{start: r_aligned + r_rsize[31:0], length: r_tail,
                                  is_free: 1'b1};
                end else begin
                    mem_addr  = AW'(r_ptr);
                    mem_wdata = '{start: r_aligned, length: r_rsize[31:0], is_free: 1'b0};
                end
            end
            S_RDN: mem_addr = AW'(r_idx + 1'b1);
            S_RDP: mem_addr = AW'(r_idx - 1'b1);
            S_MRGP: begin
                mem_we = 1'b1;
                if (prev_free) begin
                    mem_addr  = AW'(r_idx - 1'b1);
                    mem_wdata = '{start: r_rdata.start,
                                  length: r_rdata.length + r_cur.length,
                                  is_free: 1'b1};
                end else begin
                    mem_wdata = r_cur;
                end
            end
            S_DNRD: mem_addr = r_ptr[AW-1:0];
            S_DNWR: begin
                mem_we    = 1'b1;
                mem_addr  = AW'(r_ptr - CW'(r_extra));
                mem_wdata = r_rdata;
            end
            default: begin
                mem_addr = r_idx[AW-1:0];
            end
        endcase
        if (r_state == S_IDLE && cfg_init) begin
            mem_we    = 1'b1;
            mem_addr  = '0;
            mem_wdata = '{start: (i_cfg_index == CFG_START) ? i_cfg_data : r_hstart,
                          length: (i_cfg_index == CFG_LENGTH) ? i_cfg_data : r_hlen,
                          is_free: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_count  <= CW'(1);
            r_ovalid <= 1'b0;
            r_base   <= '0;
            r_hstart <= '0;
            r_hlen   <= 32'd16777216;
            r_idx    <= '0;
            r_cmd    <= CMD_ALLOC;
            r_status <= ST_OK;
            r_goff   <= '0;
            r_gsize  <= '0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE:   r_base <= i_cfg_data;
                    CFG_START:  begin r_hstart <= i_cfg_data; r_count <= CW'(1); end
                    CFG_LENGTH: begin r_hlen   <= i_cfg_data; r_count <= CW'(1); end
                    default:    r_base <= r_base;
                endcase
            end
            case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (acc) begin
                        r_cmd   <= i_command;
                        r_off   <= i_release_offset;
                        r_rsize <= rs;
                        r_amask <= align_eff - 33'd1;
                        r_idx   <= '0;
                        r_goff  <= '0;
                        r_gsize <= '0;
                        if (i_command == CMD_ALLOC) begin
                            if (i_request_size == 32'd0 || (align_eff & (align_eff - 33'd1)) != '0)
                            begin
                                r_status <= ST_INVAL;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_RD;
                            end
                        end else if (i_request_size == 32'd0) begin
                            r_status <= ST_NOMATCH;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    if (r_idx >= r_count) begin
                        r_status <= (r_cmd == CMD_ALLOC) ? ST_NOMEM : ST_NOMATCH;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_cur   <= r_rdata;
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_aligned <= f_aligned;
                    r_pad     <= f_pad;
                    r_tail    <= f_tail;
                    r_extra   <= 2'((f_pad != 32'd0)) + 2'((f_tail != 32'd0));
                    r_wstep   <= 2'd0;
                    r_ptr     <= r_count;
                    if (r_cmd == CMD_ALLOC) begin
                        if (!fit) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end else if ({1'b0, r_count} + (CW+1)'((f_pad != 32'd0))
                                     + (CW+1)'((f_tail != 32'd0)) > {1'b0, MAXC}) begin
                            r_status <= ST_NOMEM;
                            r_state  <= S_DONE;
                        end else begin
                            r_status <= ST_OK;
                            r_goff   <= f_aligned;
                            r_gsize  <= r_rsize[31:0];
                            r_state  <= S_SHRD;
                        end
                    end else if (r_cur.start == r_off && !r_cur.is_free) begin
                        r_status      <= ST_OK;
                        r_cur.is_free <= 1'b1;
                        r_mnext       <= 1'b0;
                        r_state       <= S_RDN;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                // Alloc: move entries idx+1..count-1 up by extra, top first.
                S_SHRD: begin
                    if (r_extra == 2'd0 || r_ptr <= r_idx + 1'b1) begin
                        r_ptr   <= r_idx;
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_SHWR;
                    end
                end
                S_SHWR: begin
                    r_ptr   <= r_ptr - 1'b1;
                    r_state <= S_SHRD;
                end
                S_WR: begin
                    r_ptr   <= r_ptr + 1'b1;
                    r_wstep <= r_wstep + 1'b1;
                    if (r_wstep >= r_extra) begin
                        r_count <= r_count + CW'(r_extra);
                        r_state <= S_DONE;
                    end
                end
                // Release: fold in the next entry, then the previous one, then close
                // the gap left by the removed entries.
                S_RDN: begin
                    r_state <= S_MRGN;
                end
                S_MRGN: begin
                    if (r_idx + 1'b1 < r_count && r_rdata.is_free) begin
                        r_cur.length <= r_cur.length + r_rdata.length;
                        r_mnext      <= 1'b1;
                    end
                    r_state <= S_RDP;
                end
                S_RDP: begin
                    r_state <= S_MRGP;
                end
                S_MRGP: begin
                    r_ptr   <= r_idx + CW'(1) + CW'(r_mnext);
                    r_extra <= 2'(prev_free) + 2'(r_mnext);
                    if (!prev_free && !r_mnext) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DNRD;
                    end
                end
                S_DNRD: begin
                    if (r_ptr >= r_count) begin
                        r_count <= r_count - CW'(r_extra);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DNWR;
                    end
                end
                S_DNWR: begin
                    r_ptr   <= r_ptr + 1'b1;
                    r_state <= S_DNRD;
                end
                S_DONE: begin
                    r_state  <= S_IDLE;
                    r_ovalid <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_status          = r_status;
    assign o_granted_offset  = r_goff;
    assign o_granted_size    = r_gsize;
    assign o_granted_address = (r_status == ST_OK && r_cmd == CMD_ALLOC) ? r_base + r_goff
                                                                         : 32'd0;

    `FFA_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, (r_count >= CW'(1) && r_count <= MAXC), "table count out of range")
    `FFA_ASSERT_NEXT(a_no_ready_busy, i_clk, i_rst_n, (acc), (!o_ready), "ready while busy")
    `FFA_ASSERT_IMPL(a_grant_zero, i_clk, i_rst_n, (!(o_valid && o_status != ST_OK) || o_granted_size == 32'd0), "grant on failure")
endmodule

/* tb/sv/tb_first_fit_aligned_block_allocator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Allocator testbench
// Drives allocate and release items through the block with random gaps on
// both handshakes, predicts every result from a behavioural copy of the heap
// table, and compares each result field by field in order.
// ---------------------------------------------------------------------------
module tb_first_fit_aligned_block_allocator;
    import ffa_pkg::*;

    localparam int MAX_BLOCKS = 64;
    localparam int BASE_ALIGN = 64;
    localparam int SETTLE     = 3 * MAX_BLOCKS + 20;

    typedef struct packed {
        logic        command;
        logic [31:0] size;
        logic [31:0] alignment;
        logic [31:0] offset;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] offset;
        logic [31:0] size;
        logic [31:0] address;
    } t_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_command = 1'b0;
    logic [31:0] i_request_size = '0;
    logic [31:0] i_request_alignment = '0;
    logic [31:0] i_release_offset = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_granted_offset;
    logic [31:0] o_granted_size;
    logic [31:0] o_granted_address;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    first_fit_aligned_block_allocator #(
        .MAX_BLOCKS(MAX_BLOCKS),
        .BASE_ALIGN(BASE_ALIGN)
    ) dut (.*);

    always #5 i_clk = ~i_clk;

    // Model of the heap table.
    logic [31:0] heap_base_addr, heap_origin, heap_bytes;
    logic [31:0] blk_start [MAX_BLOCKS];
    logic [31:0] blk_len [MAX_BLOCKS];
    logic        blk_free [MAX_BLOCKS];
    int          blk_count;

    t_request pending_requests[$];
    t_grant   expected_grants[$];
    logic [31:0] live_offsets[$];
    int  mismatches = 0;
    bit  feeding_done = 0;
    bit  driver_busy = 0;

    function automatic void clear_table();
        for (int k = 0; k < MAX_BLOCKS; k++) begin
            blk_start[k] = '0;
            blk_len[k] = '0;
            blk_free[k] = 1'b0;
        end
        blk_start[0] = heap_origin;
        blk_len[0] = heap_bytes;
        blk_free[0] = 1'b1;
        blk_count = 1;
    endfunction

    // Move entries from..count-1 by delta places.
    function automatic void move_entries(int from, int delta);
        if (delta > 0) begin
            for (int k = blk_count - 1; k >= from; k--) begin
                blk_start[k + delta] = blk_start[k];
                blk_len[k + delta] = blk_len[k];
                blk_free[k + delta] = blk_free[k];
            end
        end else begin
            for (int k = from; k < blk_count; k++) begin
                blk_start[k + delta] = blk_start[k];
                blk_len[k + delta] = blk_len[k];
                blk_free[k + delta] = blk_free[k];
            end
        end
        blk_count += delta;
    endfunction

    function automatic t_grant allocate_block(t_request r);
        t_grant g;
        logic [63:0] a, rsize, st, len, aligned, pad, tail;
        int extra, i;
        g = '0;
        a = (r.alignment == 0) ? BASE_ALIGN : r.alignment;
        if (r.size == 0 || (a & (a - 1)) != 0) begin
            g.status = ST_INVAL;
            return g;
        end
        rsize = ((64'(r.size) + BASE_ALIGN - 1) / BASE_ALIGN) * BASE_ALIGN;
        for (i = 0; i < blk_count; i++) begin
            if (!blk_free[i]) continue;
            st = blk_start[i];
            len = blk_len[i];
            aligned = (st + a - 1) & ~(a - 1);
            if (aligned > 64'hFFFF_FFFF) continue;
            pad = aligned - st;
            if (len < pad || len - pad < rsize) continue;
            tail = len - pad - rsize;
            extra = int'(pad != 0) + int'(tail != 0);
            if (blk_count + extra > MAX_BLOCKS) begin
                g.status = ST_NOMEM;
                return g;
            end
            if (extra != 0 && i + 1 < blk_count) move_entries(i + 1, extra);
            else blk_count += extra;
            if (pad != 0) begin
                blk_len[i] = pad[31:0];
                blk_free[i] = 1'b1;
                i++;
            end
            blk_start[i] = aligned[31:0];
            blk_len[i] = rsize[31:0];
            blk_free[i] = 1'b0;
            if (tail != 0) begin
                blk_start[i + 1] = aligned[31:0] + rsize[31:0];
                blk_len[i + 1] = tail[31:0];
                blk_free[i + 1] = 1'b1;
            end
            g.status = ST_OK;
            g.offset = aligned[31:0];
            g.size = rsize[31:0];
            g.address = heap_base_addr + aligned[31:0];
            return g;
        end
        g.status = ST_NOMEM;
        return g;
    endfunction

    function automatic t_grant release_block(t_request r);
        t_grant g;
        g = '0;
        g.status = ST_NOMATCH;
        if (r.size == 0) return g;
        for (int i = 0; i < blk_count; i++) begin
            if (blk_start[i] != r.offset || blk_free[i]) continue;
            blk_free[i] = 1'b1;
            if (i + 1 < blk_count && blk_free[i + 1]) begin
                blk_len[i] = blk_len[i] + blk_len[i + 1];
                if (i + 2 < blk_count) move_entries(i + 2, -1);
                else blk_count -= 1;
            end
            if (i > 0 && blk_free[i - 1]) begin
                blk_len[i - 1] = blk_len[i - 1] + blk_len[i];
                if (i + 1 < blk_count) move_entries(i + 1, -1);
                else blk_count -= 1;
            end
            g.status = ST_OK;
            return g;
        end
        return g;
    endfunction

    function automatic logic [31:0] random_alignment();
        case ($urandom_range(0, 9))
            0, 1, 2: return 32'd0;
            3:       return $urandom();
            4:       return 32'd1 << $urandom_range(0, 31);
            default: return 32'd1 << $urandom_range(0, 12);
        endcase
    endfunction

    function automatic logic [31:0] random_size();
        case ($urandom_range(0, 15))
            0:       return 32'd0;
            1:       return $urandom();
            2:       return 32'hFFFF_FFFF - $urandom_range(0, 63);
            default: return $urandom_range(1, 20000);
        endcase
    endfunction

    task automatic queue_alloc(logic [31:0] size, logic [31:0] alignment);
        t_request r;
        r = '{CMD_ALLOC, size, alignment, $urandom()};
        pending_requests = {pending_requests, r};
    endtask

    task automatic queue_release(logic [31:0] size, logic [31:0] offset);
        t_request r;
        r = '{CMD_RELEASE, size, $urandom(), offset};
        pending_requests = {pending_requests, r};
    endtask

    // Wait until the block has drained, then write one register.
    task automatic write_register(logic [1:0] index, logic [31:0] value);
        while (pending_requests.size() != 0 || driver_busy || expected_grants.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_BASE:   heap_base_addr = value;
            CFG_START:  begin heap_origin = value; clear_table(); end
            CFG_LENGTH: begin heap_bytes = value; clear_table(); end
            default: ;
        endcase
        live_offsets.delete();
    endtask

    // Random phase: a mix of allocations, releases of live blocks and releases of random offsets.
    task automatic queue_random(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                queue_alloc(random_size(), random_alignment());
            end else if (pick < 85 && live_offsets.size() != 0) begin
                queue_release($urandom_range(0, 30) == 0 ? 32'd0 : $urandom() | 32'd1,
                    live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
            end else begin
                queue_release($urandom(), $urandom_range(0, 1) ? $urandom()
                    : 32'($urandom_range(0, 200)) * BASE_ALIGN);
            end
        end
    endtask

    // Driver: holds valid with a steady payload until the item is taken.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                t_request r;
                t_grant g;
                r = pending_requests.pop_front();
                g = (r.command == CMD_ALLOC) ? allocate_block(r) : release_block(r);
                if (r.command == CMD_ALLOC && g.status == ST_OK)
                    live_offsets = {live_offsets, g.offset};
                expected_grants = {expected_grants, g};
                send_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                         : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
            end
            if (!(i_valid && !o_ready)) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_valid <= 1'b0;
                    driver_busy <= 1'b1;
                end else if (pending_requests.size() != 0) begin
                    i_valid <= 1'b1;
                    i_command <= pending_requests[0].command;
                    i_request_size <= pending_requests[0].size;
                    i_request_alignment <= pending_requests[0].alignment;
                    i_release_offset <= pending_requests[0].offset;
                    driver_busy <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                    driver_busy <= 1'b0;
                end
            end
        end
    end

    // Monitor with random back-pressure.
    int stall = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                t_grant want;
                if (expected_grants.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d offset %h",
                            o_status, o_granted_offset);
                end else begin
                    want = expected_grants.pop_front();
                    if (o_status !== want.status || o_granted_offset !== want.offset
                            || o_granted_size !== want.size
                            || o_granted_address !== want.address) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %0d %h %h %h, got %0d %h %h %h",
                                want.status, want.offset, want.size, want.address,
                                o_status, o_granted_offset, o_granted_size,
                                o_granted_address);
                    end
                end
            end
            if (stall > 0) begin
                stall <= stall - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall <= ($urandom_range(0, 12) == 0) ? $urandom_range(10, 80)
                           : $urandom_range(1, 3);
            end
        end
    end

    initial begin
        heap_base_addr = '0;
        heap_origin = '0;
        heap_bytes = 32'd16777216;
        clear_table();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: the reset table, every special case, then field extremes.
        queue_alloc(32'd0, 32'd0);
        queue_alloc(32'd1, 32'd3);
        queue_alloc(32'd1, 32'hFFFF_FFFF);
        queue_alloc(32'hFFFF_FFFF, 32'd0);
        queue_alloc(32'd1, 32'd0);
        queue_alloc(32'd100, 32'd4096);
        queue_alloc(32'd64, 32'h8000_0000);
        queue_release(32'd0, 32'd0);
        queue_release(32'd1, 32'd12345);
        queue_release(32'hFFFF_FFFF, 32'd0);
        queue_release(32'd1, 32'd4096);
        queue_alloc(32'd1, 32'd1);
        for (int k = 0; k < 70; k++) queue_alloc(32'd1, 32'd128);
        write_register(CFG_BASE, 32'hFFFF_FFC0);
        write_register(CFG_START, 32'hFFFF_FF00);
        write_register(CFG_LENGTH, 32'hFFFF_FFFF);
        queue_alloc(32'd64, 32'd0);
        queue_alloc(32'd64, 32'd0);
        queue_alloc(32'd256, 32'd256);
        queue_alloc(32'd1, 32'h8000_0000);
        write_register(CFG_LENGTH, 32'd0);
        queue_alloc(32'd1, 32'd0);
        queue_release(32'd1, 32'hFFFF_FF00);

        write_register(CFG_START, 32'd0);
        write_register(CFG_LENGTH, 32'd65536);
        write_register(CFG_BASE, 32'h1000_0000);
        queue_random(400);
        write_register(CFG_START, 32'd37);
        write_register(CFG_LENGTH, 32'd1 << 20);
        write_register(CFG_BASE, $urandom());
        queue_random(400);
        write_register(CFG_START, 32'hFFFF_0000);
        write_register(CFG_LENGTH, 32'hFFFF_FFFF);
        queue_random(400);
        feeding_done = 1;
    end

    initial begin : finish_run
        wait (feeding_done);
        while (pending_requests.size() != 0 || driver_busy || expected_grants.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && expected_grants.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
